// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the run-length mask decoder modules.
// No dependencies; included by every file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define RMD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rmd assertion failed");
// Same-cycle implication.
`define RMD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmd assertion failed");
// Next-cycle implication.
`define RMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmd assertion failed");
`else
`define RMD_ASSERT(label, clk, rst_n, prop)
`define RMD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RMD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/rmd_pkg.sv =====
// Shared types and constants of the run-length mask decoder.
// No dependencies; imported by the interfaces and every module.
package rmd_pkg;

    localparam int DIM_W  = 12;
    localparam int LEN_W  = 10;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 2;

    // Input commands.
    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_SPAN   = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_OPAQUE = 2'd3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_MASK_WIDTH     = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MASK_HEIGHT    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_ENCODED_LENGTH = 2'd2;

    // Run extension offsets after one or two zero bytes.
    localparam logic [LEN_W-1:0] EXT1_BIAS = 10'd255;
    localparam logic [LEN_W-1:0] EXT2_BIAS = 10'd511;

    typedef struct packed {
        logic [1:0]       kind;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] column;
        logic [LEN_W-1:0] length;
        logic             opaque;
        logic             last;
    } result_t;

    // One decoded byte worth of results: one or two.
    typedef struct packed {
        result_t first;
        result_t second;
        logic    has_second;
    } q_entry_t;

endpackage

// ===== hdl/rmd_if.sv =====
// Valid/ready channel interfaces for command words and result words.
// Depends on rmd_pkg for field widths.
interface rmd_cmd_if
    import rmd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface rmd_res_if
    import rmd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       kind;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] column;
    logic [LEN_W-1:0] length;
    logic             opaque;
    logic             last;

    modport source (
        output valid, output kind, output row, output column,
        output length, output opaque, output last, input ready
    );
    modport sink (
        input valid, input kind, input row, input column,
        input length, input opaque, input last, output ready
    );
endinterface

// ===== hdl/rmd_front.sv =====
// Front end: accepts command words, tracks the decode state and builds results.
// Depends on rmd_pkg and the rmd_cmd_if interface.
module rmd_front
    import rmd_pkg::*;
#(
    parameter int MAX_ENCODED_BYTES = 480
)
(
    input  logic             clk,
    input  logic             rst_n,
    rmd_cmd_if.sink          cmd,
    input  logic [DIM_W-1:0] mask_width,
    input  logic [DIM_W-1:0] mask_height,
    input  logic [LEN_W-1:0] encoded_length,
    input  logic             q_full,
    output logic             push,
    output q_entry_t         push_entry
);

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_PARITY = 5'b00010,
        PH_RUN    = 5'b00100,
        PH_EXT1   = 5'b01000,
        PH_EXT2   = 5'b10000
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] parity_reg, parity_next;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic [DIM_W-1:0]  column_reg, column_next;
    logic [LEN_W-1:0]  bytes_reg, bytes_next;

    logic              accept;
    logic              do_run;
    logic              do_check;
    logic [LEN_W-1:0]  run_len;
    logic [DIM_W-1:0]  remain;
    logic [DIM_W-1:0]  count;
    logic [DIM_W-1:0]  column_after;
    logic [DIM_W-1:0]  row_inc;
    logic              span_valid;
    logic              tail_valid;
    logic [1:0]        tail_kind;
    result_t           span_res;
    result_t           tail_res;

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && cmd.ready;

    // Run clamp to the rest of the row.
    assign remain  = (column_reg < mask_width) ? (mask_width - column_reg) : '0;
    assign count   = (DIM_W'(run_len) < remain) ? DIM_W'(run_len) : remain;
    assign row_inc = row_reg + 1'b1;

    // Decode state transition for one accepted word.
    always_comb
    begin
        phase_next   = phase_reg;
        parity_next  = parity_reg;
        row_next     = row_reg;
        column_next  = column_reg;
        bytes_next   = bytes_reg;
        do_run       = 1'b0;
        do_check     = 1'b0;
        run_len      = '0;
        tail_valid   = 1'b0;
        tail_kind    = KIND_DONE;
        column_after = column_reg;

        if (accept)
        begin
            if (cmd.command == CMD_BEGIN)
            begin
                row_next    = '0;
                column_next = '0;
                bytes_next  = '0;
                parity_next = '0;
                phase_next  = PH_IDLE;
                if (encoded_length > LEN_W'(MAX_ENCODED_BYTES))
                begin
                    tail_valid = 1'b1;
                    tail_kind  = KIND_ERROR;
                end
                else if (encoded_length == '0)
                begin
                    tail_valid = 1'b1;
                    tail_kind  = KIND_OPAQUE;
                end
                else if (mask_height == '0)
                begin
                    tail_valid = 1'b1;
                    tail_kind  = KIND_DONE;
                end
                else
                begin
                    phase_next = PH_PARITY;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                bytes_next = bytes_reg + 1'b1;
                case (phase_reg)
                    PH_PARITY:
                    begin
                        parity_next = cmd.data_byte;
                        phase_next  = PH_RUN;
                        do_check    = 1'b1;
                    end
                    PH_RUN:
                    begin
                        if (cmd.data_byte != '0)
                        begin
                            do_run  = 1'b1;
                            run_len = LEN_W'(cmd.data_byte);
                        end
                        else
                        begin
                            phase_next = PH_EXT1;
                        end
                    end
                    PH_EXT1:
                    begin
                        if (cmd.data_byte != '0)
                        begin
                            do_run  = 1'b1;
                            run_len = LEN_W'(cmd.data_byte) + EXT1_BIAS;
                        end
                        else
                        begin
                            phase_next = PH_EXT2;
                        end
                    end
                    PH_EXT2:
                    begin
                        do_run  = 1'b1;
                        run_len = LEN_W'(cmd.data_byte) + EXT2_BIAS;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase

                // A run advances the column and flips the parity.
                if (do_run)
                begin
                    column_after = column_reg + count;
                    column_next  = column_after;
                    parity_next  = BYTE_W'(8'd0 - parity_reg);
                    phase_next   = PH_RUN;
                    do_check     = 1'b1;
                end

                // Row completion, and mask completion on the last row.
                if (do_check && (column_after >= mask_width))
                begin
                    column_next = '0;
                    row_next    = row_inc;
                    if (row_inc >= mask_height)
                    begin
                        phase_next = PH_IDLE;
                        tail_valid = 1'b1;
                        tail_kind  = KIND_DONE;
                    end
                    else
                    begin
                        phase_next = PH_PARITY;
                    end
                end

                // Stream exhausted before the mask is complete.
                if ((phase_next != PH_IDLE) && (bytes_next >= encoded_length))
                begin
                    phase_next = PH_IDLE;
                    tail_valid = 1'b1;
                    tail_kind  = KIND_ERROR;
                end
            end
        end
    end

    // Result words for the queue.
    assign span_valid = do_run;
    always_comb
    begin
        span_res        = '0;
        span_res.kind   = KIND_SPAN;
        span_res.row    = row_reg;
        span_res.column = column_reg;
        span_res.length = count[LEN_W-1:0];
        span_res.opaque = ~parity_reg[BYTE_W-1];
        span_res.last   = 1'b0;

        tail_res        = '0;
        tail_res.kind   = tail_kind;
        tail_res.opaque = (tail_kind == KIND_OPAQUE);
        tail_res.last   = 1'b1;
    end

    assign push                  = accept && (span_valid || tail_valid);
    assign push_entry.first      = span_valid ? span_res : tail_res;
    assign push_entry.second     = tail_res;
    assign push_entry.has_second = span_valid && tail_valid;

    // Decode state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            parity_reg <= '0;
            row_reg    <= '0;
            column_reg <= '0;
            bytes_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            parity_reg <= parity_next;
            row_reg    <= row_next;
            column_reg <= column_next;
            bytes_reg  <= bytes_next;
        end
    end

endmodule

// ===== hdl/rmd_queue.sv =====
// Short result queue between the decode front end and the output back end.
// Depends on rmd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rmd_queue
    import rmd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output q_entry_t pop_entry,
    output logic     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t           entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = entries_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `RMD_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `RMD_ASSERT_IMPL(a_push_not_full, clk, rst_n, push, !full)
    `RMD_ASSERT_IMPL(a_pop_not_empty, clk, rst_n, pop, !empty)
    `RMD_ASSERT_IMPL(a_empty_ptrs, clk, rst_n, empty, wr_ptr_reg == rd_ptr_reg)

endmodule

// ===== hdl/rmd_back.sv =====
// Back end: sends the results of queue entries one per cycle while res.ready.
// Depends on rmd_pkg, the rmd_res_if interface and assert_macros.svh.
`include "assert_macros.svh"
module rmd_back
    import rmd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     empty,
    input  q_entry_t pop_entry,
    output logic     pop,
    rmd_res_if.source res
);

    result_t out_reg;
    result_t pend_reg;
    logic    out_valid_reg, out_valid_next;
    logic    pend_valid_reg, pend_valid_next;
    logic    load_ok;

    // The output register can take a new word when it is empty or being taken.
    assign load_ok = !out_valid_reg || res.ready;
    assign pop     = load_ok && !pend_valid_reg && !empty;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        if (load_ok)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (!empty)
            begin
                out_valid_next  = 1'b1;
                pend_valid_next = pop_entry.has_second;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Output word and the held second word of an entry.
    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            if (pend_valid_reg)
            begin
                out_reg <= pend_reg;
            end
            else if (!empty)
            begin
                out_reg  <= pop_entry.first;
                pend_reg <= pop_entry.second;
            end
        end
    end

    assign res.valid  = out_valid_reg;
    assign res.kind   = out_reg.kind;
    assign res.row    = out_reg.row;
    assign res.column = out_reg.column;
    assign res.length = out_reg.length;
    assign res.opaque = out_reg.opaque;
    assign res.last   = out_reg.last;

    `RMD_ASSERT_IMPL(a_pend_has_out, clk, rst_n, pend_valid_reg, out_valid_reg)
    `RMD_ASSERT_IMPL(a_pend_first_not_last, clk, rst_n, pend_valid_reg, !out_reg.last)
    `RMD_ASSERT_NEXT(a_pop_fills_out, clk, rst_n, pop, out_valid_reg)

endmodule

// ===== hdl/rle_mask_row_decoder.sv =====
// Run-length mask decoder: one encoded byte per cycle, spans out one per cycle while
// the receiver is ready; a result word is queued and then registered for the output.
// Throughput: one command word per cycle while the result queue has room; a byte
// that gives two results sends them in turn through the one output port.
// Reset clears decode state, queue and output valid; registers reset to 1, 1 and 0.
module rle_mask_row_decoder
    import rmd_pkg::*;
#(
    parameter int MAX_ENCODED_BYTES = 480,
    parameter int QUEUE_DEPTH       = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    rmd_cmd_if.sink          cmd,
    rmd_res_if.source        res,
    input  logic             cfg_write,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0] cfg_data
);

    logic [DIM_W-1:0] mask_width_reg;
    logic [DIM_W-1:0] mask_height_reg;
    logic [LEN_W-1:0] encoded_length_reg;

    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;
    q_entry_t q_in;
    q_entry_t q_out;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_width_reg     <= DIM_W'(1);
            mask_height_reg    <= DIM_W'(1);
            encoded_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MASK_WIDTH:     mask_width_reg     <= cfg_data;
                CFG_MASK_HEIGHT:    mask_height_reg    <= cfg_data;
                CFG_ENCODED_LENGTH: encoded_length_reg <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Decode front end.
    rmd_front #(
        .MAX_ENCODED_BYTES (MAX_ENCODED_BYTES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .mask_width     (mask_width_reg),
        .mask_height    (mask_height_reg),
        .encoded_length (encoded_length_reg),
        .q_full         (q_full),
        .push           (q_push),
        .push_entry     (q_in)
    );

    // Result queue.
    rmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_out),
        .empty      (q_empty)
    );

    // Output back end.
    rmd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .pop_entry (q_out),
        .pop       (q_pop),
        .res       (res)
    );

endmodule

// ===== bench/tb_rle_mask_row_decoder.sv =====
// Self-checking bench for rle_mask_row_decoder: drives encoded mask words, predicts
// the span, done, error and opaque words, and compares them with the block's output.
// Depends on rmd_pkg and the rmd_cmd_if / rmd_res_if channel interfaces.
module tb_rle_mask_row_decoder;
    import rmd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STREAM_LIMIT   = 480;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_WORDS   = 1850;
    localparam int MAX_REPORTS    = 100;

    typedef enum logic [2:0] {DEC_IDLE, DEC_PARITY, DEC_RUN, DEC_EXT1, DEC_EXT2} dec_phase_t;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] data_byte;
    } cmd_word_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_write;
    logic [IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0] cfg_data;

    rmd_cmd_if cmd_if ();
    rmd_res_if res_if ();

    rle_mask_row_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .res       (res_if),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copies and decode state of the mask predictor.
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [LEN_W-1:0]  length_reg;
    dec_phase_t        dec_phase;
    logic [BYTE_W-1:0] parity;
    logic [DIM_W-1:0]  cur_row;
    logic [DIM_W-1:0]  cur_col;
    logic [LEN_W-1:0]  taken;

    result_t pending_results[$];
    int      send_idle_pct;
    int      recv_stall_pct;
    int      fail_count;
    int      sent_words;
    int      stalled_cycles;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(negedge clk)
    begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic push_result(logic [1:0] kind, logic [DIM_W-1:0] r, logic [DIM_W-1:0] c,
                               logic [LEN_W-1:0] len, logic opq, logic lst);
        pending_results.push_back(result_t'{kind, r, c, len, opq, lst});
    endtask

    // A full row moves to the next one; past the last row the decode is done.
    task automatic close_row_if_full();
        if (cur_col >= width_reg)
        begin
            cur_col = '0;
            cur_row = cur_row + 1'b1;
            if (cur_row >= height_reg)
            begin
                dec_phase = DEC_IDLE;
                push_result(KIND_DONE, '0, '0, '0, 1'b0, 1'b1);
            end
            else
            begin
                dec_phase = DEC_PARITY;
            end
        end
    endtask

    // A run is clamped to what is left of the row, then the parity flips sign.
    task automatic emit_span(int unsigned run);
        int unsigned room;
        int unsigned span;
        room = (cur_col < width_reg) ? width_reg - cur_col : 0;
        span = (run < room) ? run : room;
        push_result(KIND_SPAN, cur_row, cur_col, span[LEN_W-1:0], ~parity[7], 1'b0);
        cur_col   = cur_col + span[DIM_W-1:0];
        parity    = 8'd0 - parity;
        dec_phase = DEC_RUN;
        close_row_if_full();
    endtask

    // Works out the result words of one accepted command word; data words
    // while idle give nothing.
    task automatic predict_mask_word(logic command, logic [BYTE_W-1:0] b);
        if (command == CMD_BEGIN)
        begin
            cur_row   = '0;
            cur_col   = '0;
            taken     = '0;
            parity    = '0;
            dec_phase = DEC_IDLE;
            if (length_reg > STREAM_LIMIT)
                push_result(KIND_ERROR, '0, '0, '0, 1'b0, 1'b1);
            else if (length_reg == 0)
                push_result(KIND_OPAQUE, '0, '0, '0, 1'b1, 1'b1);
            else if (height_reg == 0)
                push_result(KIND_DONE, '0, '0, '0, 1'b0, 1'b1);
            else
                dec_phase = DEC_PARITY;
        end
        else if (dec_phase != DEC_IDLE)
        begin
            taken = taken + 1'b1;
            case (dec_phase)
                DEC_PARITY:
                begin
                    parity    = b;
                    dec_phase = DEC_RUN;
                    close_row_if_full();
                end
                DEC_RUN:
                begin
                    if (b != 0)
                        emit_span(b);
                    else
                        dec_phase = DEC_EXT1;
                end
                DEC_EXT1:
                begin
                    if (b != 0)
                        emit_span(int'(b) + int'(EXT1_BIAS));
                    else
                        dec_phase = DEC_EXT2;
                end
                default:
                begin
                    emit_span(int'(b) + int'(EXT2_BIAS));
                end
            endcase
            // The stream ended before the mask did.
            if (dec_phase != DEC_IDLE && taken >= length_reg)
            begin
                dec_phase = DEC_IDLE;
                push_result(KIND_ERROR, '0, '0, '0, 1'b0, 1'b1);
            end
        end
    endtask

    // Sends one command word, with random gaps before it, and predicts its results.
    task automatic send_word(logic command, logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.command   <= command;
        cmd_if.data_byte <= b;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        predict_mask_word(command, b);
        sent_words++;
        @(negedge clk);
    endtask

    // Stops sending and lets every expected word arrive.
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic [IDX_W-1:0] idx, int unsigned value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[DIM_W-1:0];
        @(posedge clk);
        case (idx)
            CFG_MASK_WIDTH:     width_reg  = value[DIM_W-1:0];
            CFG_MASK_HEIGHT:    height_reg = value[DIM_W-1:0];
            CFG_ENCODED_LENGTH: length_reg = value[LEN_W-1:0];
            default:            ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned len);
        write_register(CFG_MASK_WIDTH, w);
        write_register(CFG_MASK_HEIGHT, h);
        write_register(CFG_ENCODED_LENGTH, len);
    endtask

    // Begin words that finish at once: too long, empty stream, zero height.
    task automatic test_begin_shortcuts();
        write_register(CFG_ENCODED_LENGTH, STREAM_LIMIT + 1);
        send_word(CMD_BEGIN, 8'hFF);
        wait_drained();
        write_register(CFG_ENCODED_LENGTH, 0);
        send_word(CMD_BEGIN, 8'h00);
        wait_drained();
        set_geometry(5, 0, 10);
        send_word(CMD_BEGIN, 8'hA5);
        // A data word while idle is dropped.
        send_word(CMD_DATA, 8'h5A);
        wait_drained();
    endtask

    // Widest row, longest stream, both run extensions, then a restart mid-row.
    task automatic test_long_runs();
        set_geometry(4095, 2, STREAM_LIMIT);
        send_word(CMD_BEGIN, 8'h00);
        send_word(CMD_DATA, 8'h7F);
        send_word(CMD_DATA, 8'h00);
        send_word(CMD_DATA, 8'h00);
        send_word(CMD_DATA, 8'hFF);
        send_word(CMD_DATA, 8'h00);
        send_word(CMD_DATA, 8'h01);
        send_word(CMD_DATA, 8'hFF);
        send_word(CMD_BEGIN, 8'hFF);
        wait_drained();
    endtask

    // Zero width: every parity word completes a row; a word after done is dropped.
    task automatic test_zero_width_rows();
        set_geometry(0, 3, 5);
        send_word(CMD_BEGIN, 8'h00);
        send_word(CMD_DATA, 8'h80);
        send_word(CMD_DATA, 8'h7F);
        send_word(CMD_DATA, 8'h01);
        send_word(CMD_DATA, 8'h00);
        wait_drained();
    endtask

    // The last stream word closes a row but not the mask: span, then error.
    task automatic test_stream_exhausted();
        set_geometry(10, 2, 3);
        send_word(CMD_BEGIN, 8'h00);
        send_word(CMD_DATA, 8'h80);
        send_word(CMD_DATA, 8'h04);
        send_word(CMD_DATA, 8'hFF);
        wait_drained();
    endtask

    // The width drops below the current column in the middle of a row.
    task automatic test_width_lowered_mid_row();
        set_geometry(20, 1, 40);
        send_word(CMD_BEGIN, 8'h00);
        send_word(CMD_DATA, 8'h05);
        send_word(CMD_DATA, 8'h0C);
        wait_drained();
        write_register(CFG_MASK_WIDTH, 8);
        send_word(CMD_DATA, 8'h03);
        wait_drained();
    endtask

    // Random masks, mostly well-formed streams, under four idling patterns.
    task automatic test_random_masks();
        int        send_pct[4];
        int        stall_pct[4];
        cmd_word_t stream[$];
        int        goal;
        int        w;
        int        h;
        int        len;
        int        r;
        int        col;
        int        run;
        int        room;
        int        pick;
        int        nbytes;
        send_pct  = '{0, 88, 0, 36};
        stall_pct = '{0, 0, 88, 36};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = stall_pct[p];
            goal = sent_words + RANDOM_WORDS / 4;
            while (sent_words < goal)
            begin
                pick = $urandom_range(99);
                w = (pick < 5) ? 0 : (pick < 10) ? 4095 :
                    (pick < 15) ? $urandom_range(4095) : $urandom_range(1, 24);
                pick = $urandom_range(99);
                h = (pick < 4) ? 0 : (pick < 7) ? 4095 : $urandom_range(1, 4);
                stream.delete();
                stream.push_back('{CMD_BEGIN, 8'($urandom)});
                if ($urandom_range(99) < 10)
                begin
                    // Noise: random words with an occasional restart.
                    repeat ($urandom_range(1, 30))
                        stream.push_back('{($urandom_range(15) == 0) ? CMD_BEGIN : CMD_DATA,
                                           8'($urandom)});
                end
                else
                begin
                    // Well-formed rows: a parity word, then runs up to the row end.
                    r = 0;
                    while (r < h && stream.size() <= STREAM_LIMIT)
                    begin
                        stream.push_back('{CMD_DATA, 8'($urandom)});
                        col = 0;
                        while (col < w && stream.size() <= STREAM_LIMIT)
                        begin
                            room = w - col;
                            pick = $urandom_range(99);
                            if (pick < 60)
                                run = $urandom_range(1, (room < 255) ? room : 255);
                            else if (pick < 75)
                                run = $urandom_range(1, 255);
                            else if (pick < 90)
                                run = $urandom_range(256, 510);
                            else
                                run = $urandom_range(511, 766);
                            if (run <= int'(EXT1_BIAS))
                            begin
                                stream.push_back('{CMD_DATA, 8'(run)});
                            end
                            else if (run < int'(EXT2_BIAS))
                            begin
                                stream.push_back('{CMD_DATA, 8'd0});
                                stream.push_back('{CMD_DATA, 8'(run - int'(EXT1_BIAS))});
                            end
                            else
                            begin
                                stream.push_back('{CMD_DATA, 8'd0});
                                stream.push_back('{CMD_DATA, 8'd0});
                                stream.push_back('{CMD_DATA, 8'(run - int'(EXT2_BIAS))});
                            end
                            col += (run < room) ? run : room;
                        end
                        r++;
                    end
                    // A broken sequence: restart somewhere inside the stream.
                    if ($urandom_range(99) < 5 && stream.size() > 2)
                        stream.insert($urandom_range(1, stream.size() - 1),
                                      '{CMD_BEGIN, 8'($urandom)});
                end
                // Stream length: exact, with slack, cut short, empty, too long or at the limit.
                nbytes = stream.size() - 1;
                pick = $urandom_range(99);
                if (pick < 55)
                    len = nbytes;
                else if (pick < 70)
                    len = nbytes + $urandom_range(1, 8);
                else if (pick < 85)
                    len = $urandom_range(1, (nbytes > 1) ? nbytes : 1);
                else if (pick < 90)
                    len = 0;
                else if (pick < 95)
                    len = $urandom_range(STREAM_LIMIT + 1, 1023);
                else
                    len = STREAM_LIMIT;
                if (len > 1023)
                    len = 1023;
                if ($urandom_range(99) < 30)
                    repeat ($urandom_range(1, 3))
                        stream.push_back('{CMD_DATA, 8'($urandom)});
                set_geometry(w, h, len);
                foreach (stream[i])
                    send_word(stream[i].command, stream[i].data_byte);
                wait_drained();
            end
        end
    endtask

    task automatic check_field(string name, logic [DIM_W-1:0] want, logic [DIM_W-1:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Each result word is checked against the oldest expectation; the watchdog
    // ends the run when no word moves on either channel for too long.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $error("result word with no expectation: kind %0d row %0d column %0d",
                           res_if.kind, res_if.row, res_if.column);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, res_if.kind);
                check_field("row", want.row, res_if.row);
                check_field("column", want.column, res_if.column);
                check_field("length", want.length, res_if.length);
                check_field("opaque", want.opaque, res_if.opaque);
                check_field("last", want.last, res_if.last);
            end
        end
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        cmd_if.valid     = 1'b0;
        cmd_if.command   = CMD_BEGIN;
        cmd_if.data_byte = '0;
        res_if.ready     = 1'b0;
        cfg_write        = 1'b0;
        cfg_index        = CFG_MASK_WIDTH;
        cfg_data         = '0;
        rst_n            = 1'b0;
        width_reg        = 1;
        height_reg       = 1;
        length_reg       = 0;
        dec_phase        = DEC_IDLE;
        parity           = '0;
        cur_row          = '0;
        cur_col          = '0;
        taken            = '0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        fail_count       = 0;
        sent_words       = 0;
        stalled_cycles   = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_begin_shortcuts();
        test_long_runs();
        test_zero_width_rows();
        test_stream_exhausted();
        test_width_lowered_mid_row();
        test_random_masks();
        wait_drained();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rmd_pkg.sv
hdl/rmd_if.sv
hdl/rmd_front.sv
hdl/rmd_queue.sv
hdl/rmd_back.sv
hdl/rle_mask_row_decoder.sv
bench/tb_rle_mask_row_decoder.sv
